/* rtl/core/afnd_pkg.sv */
// Shared types, widths, register indexes and helpers for the aspect-fit
// nearest-neighbour downscaler. No dependencies; every other file imports it.
package afnd_pkg;

  localparam int CH_W       = 8;
  localparam int SIDE_W     = 13;
  localparam int DIM_W      = 15;
  localparam int POS_W      = 14;
  localparam int NUM_W      = SIDE_W + DIM_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int QUEUE_DEPTH = 2;

  // Largest source dimension handled; bigger register values are clamped
  localparam logic [DIM_W-1:0] MAX_DIM = 15'd16384;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [SIDE_W-1:0] MAX_SIDE_RST = 13'd256;
  localparam logic [DIM_W-1:0]  DIM_RST      = 15'd1;

  // Source pixel word
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } in_word_t;

  // Thumbnail pixel word
  typedef struct packed {
    logic [CH_W-1:0]  out_blue;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_alpha;
    logic [POS_W-1:0] dst_x;
    logic [POS_W-1:0] dst_y;
    logic [DIM_W-1:0] dst_width;
    logic [DIM_W-1:0] dst_height;
    logic             frame_last;
  } out_word_t;

  // Selected pixel as queued between front and back
  typedef struct packed {
    in_word_t         pix;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             last;
  } sel_entry_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DIM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [DIM_W-1:0] rem;
  } div_rsp_t;

  // Source dimension: zero reads as one, oversize clamps to MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_RST;
    else if (v > MAX_DIM) r = MAX_DIM;
    else r = v;
    return r;
  endfunction

  // Square side: zero reads as one
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = (v == '0) ? SIDE_W'(1) : v;
    return r;
  endfunction

endpackage

/* rtl/core/afnd_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle, NUM_W-bit quotient.
// Depends on afnd_pkg for widths and the request/response structs.
module afnd_div import afnd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t div_req,
  output div_rsp_t div_rsp
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DIM_W-1:0] rem_r, rem_nxt;
  logic [DIM_W-1:0] den_r, den_nxt;
  logic [DIM_W:0]   trial;
  logic [DIM_W:0]   diff;

  // One shift-subtract step
  always_comb begin
    trial    = {rem_r, num_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (div_req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      num_nxt  = div_req.num;
      rem_nxt  = '0;
      den_nxt  = div_req.den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DIM_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIM_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign div_rsp.done = done_r;
  assign div_rsp.quo  = num_r;
  assign div_rsp.rem  = rem_r;

endmodule

/* rtl/core/afnd_front.sv */
// Front end: configuration registers, frame size sequencer and pixel selection.
// Depends on afnd_pkg; drives the shared divider and pushes into the queue.
module afnd_front import afnd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  in_word_t              in_word,
  output logic                  full,
  input  logic                  q_full,
  output logic                  q_push,
  output sel_entry_t            q_entry,
  output div_req_t              div_req,
  input  div_rsp_t              div_rsp
);

  // Size sequencer states
  localparam logic [2:0] SEQ_IDLE   = 3'd0;
  localparam logic [2:0] SEQ_LFIT   = 3'd1;
  localparam logic [2:0] SEQ_WFIT   = 3'd2;
  localparam logic [2:0] SEQ_LX     = 3'd3;
  localparam logic [2:0] SEQ_WX     = 3'd4;
  localparam logic [2:0] SEQ_LY     = 3'd5;
  localparam logic [2:0] SEQ_WY     = 3'd6;

  logic [SIDE_W-1:0] max_side_r;
  logic [DIM_W-1:0]  src_width_r, src_height_r;
  logic              dims_ok_r;
  logic [2:0]        seq_r;
  logic [NUM_W-1:0]  prod_r;
  logic [DIM_W-1:0]  den_fit_r;
  logic              wide_r;
  logic [DIM_W-1:0]  fit_w_r, fit_h_r;
  logic [DIM_W-1:0]  qx_r, rx_r, qy_r, ry_r;

  logic [DIM_W-1:0] src_col_r, src_col_nxt, src_row_r, src_row_nxt;
  logic [DIM_W-1:0] out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic [DIM_W-1:0] pick_col_r, pick_col_nxt, pick_row_r, pick_row_nxt;
  logic [DIM_W-1:0] rem_col_r, rem_col_nxt, rem_row_r, rem_row_nxt;

  logic [SIDE_W-1:0] m;
  logic [DIM_W-1:0]  sw, sh;
  logic              fits, wide, cfg_hit;
  logic [DIM_W-1:0]  fit_short;

  logic              frame_start, row_sel, emit, accept, row_end;
  logic [DIM_W-1:0]  oc_col, oc_row, pk_col, pk_row, rc_col, rc_row;
  logic [DIM_W:0]    col_sum, col_sub, row_sum, row_sub, col_pick, row_pick;
  logic              col_wrap, row_wrap;

  // Effective sizes
  always_comb begin
    m         = eff_side(max_side_r);
    sw        = eff_dim(src_width_r);
    sh        = eff_dim(src_height_r);
    fits      = (sw <= DIM_W'(m)) && (sh <= DIM_W'(m));
    wide      = sw >= sh;
    cfg_hit   = cfg_we && (cfg_idx == REG_MAX_SIDE || cfg_idx == REG_SRC_WIDTH ||
                           cfg_idx == REG_SRC_HEIGHT);
    fit_short = (div_rsp.quo == '0) ? DIM_W'(1) : div_rsp.quo[DIM_W-1:0];
  end

  // Divider requests: fitted short side when the source must shrink, then column and row step sizes
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = prod_r;
    div_req.den   = den_fit_r;
    case (seq_r)
      SEQ_LFIT: div_req.start = 1'b1;
      SEQ_LX: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(sw);
        div_req.den   = fit_w_r;
      end
      SEQ_LY: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(sh);
        div_req.den   = fit_h_r;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  // Configuration registers and size sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_side_r   <= MAX_SIDE_RST;
      src_width_r  <= DIM_RST;
      src_height_r <= DIM_RST;
      dims_ok_r    <= 1'b0;
      seq_r        <= SEQ_IDLE;
    end else if (cfg_hit) begin
      case (cfg_idx)
        REG_MAX_SIDE:   max_side_r   <= cfg_data[SIDE_W-1:0];
        REG_SRC_WIDTH:  src_width_r  <= cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_data[DIM_W-1:0];
        default:        max_side_r   <= max_side_r;
      endcase
      dims_ok_r <= 1'b0;
      seq_r     <= SEQ_IDLE;
    end else begin
      case (seq_r)
        SEQ_IDLE: begin
          if (!dims_ok_r) begin
            if (fits) begin
              fit_w_r <= sw;
              fit_h_r <= sh;
              seq_r   <= SEQ_LX;
            end else begin
              prod_r    <= wide ? NUM_W'(sh) * NUM_W'(m) : NUM_W'(sw) * NUM_W'(m);
              den_fit_r <= wide ? sw : sh;
              wide_r    <= wide;
              seq_r     <= SEQ_LFIT;
            end
          end
        end
        SEQ_LFIT: seq_r <= SEQ_WFIT;
        SEQ_WFIT: begin
          if (div_rsp.done) begin
            fit_w_r <= wide_r ? DIM_W'(m) : fit_short;
            fit_h_r <= wide_r ? fit_short : DIM_W'(m);
            seq_r   <= SEQ_LX;
          end
        end
        SEQ_LX: seq_r <= SEQ_WX;
        SEQ_WX: begin
          if (div_rsp.done) begin
            qx_r  <= div_rsp.quo[DIM_W-1:0];
            rx_r  <= div_rsp.rem;
            seq_r <= SEQ_LY;
          end
        end
        SEQ_LY: seq_r <= SEQ_WY;
        SEQ_WY: begin
          if (div_rsp.done) begin
            qy_r      <= div_rsp.quo[DIM_W-1:0];
            ry_r      <= div_rsp.rem;
            dims_ok_r <= 1'b1;
            seq_r     <= SEQ_IDLE;
          end
        end
        default: seq_r <= SEQ_IDLE;
      endcase
    end
  end

  // Pixel selection with incremental nearest-neighbour stepping
  always_comb begin
    full        = !dims_ok_r || q_full;
    accept      = push && !full;
    frame_start = (src_col_r == '0) && (src_row_r == '0);
    oc_col = frame_start ? '0 : out_col_r;
    oc_row = frame_start ? '0 : out_row_r;
    pk_col = frame_start ? '0 : pick_col_r;
    pk_row = frame_start ? '0 : pick_row_r;
    rc_col = frame_start ? '0 : rem_col_r;
    rc_row = frame_start ? '0 : rem_row_r;

    row_sel = (oc_row < fit_h_r) && (src_row_r == pk_row);
    emit    = row_sel && (oc_col < fit_w_r) && (src_col_r == pk_col);
    row_end = ({1'b0, src_col_r} + (DIM_W+1)'(1)) >= {1'b0, sw};

    col_sum  = {1'b0, rc_col} + {1'b0, rx_r};
    col_sub  = col_sum - {1'b0, fit_w_r};
    col_wrap = col_sum >= {1'b0, fit_w_r};
    col_pick = {1'b0, pk_col} + {1'b0, qx_r} + {{DIM_W{1'b0}}, col_wrap};
    row_sum  = {1'b0, rc_row} + {1'b0, ry_r};
    row_sub  = row_sum - {1'b0, fit_h_r};
    row_wrap = row_sum >= {1'b0, fit_h_r};
    row_pick = {1'b0, pk_row} + {1'b0, qy_r} + {{DIM_W{1'b0}}, row_wrap};

    src_col_nxt  = src_col_r;
    src_row_nxt  = src_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    pick_col_nxt = pick_col_r;
    pick_row_nxt = pick_row_r;
    rem_col_nxt  = rem_col_r;
    rem_row_nxt  = rem_row_r;

    if (cfg_hit) begin
      // Any register write restarts the frame
      src_col_nxt = '0;
      src_row_nxt = '0;
    end else if (accept) begin
      out_col_nxt  = oc_col;
      out_row_nxt  = oc_row;
      pick_col_nxt = pk_col;
      pick_row_nxt = pk_row;
      rem_col_nxt  = rc_col;
      rem_row_nxt  = rc_row;
      if (emit) begin
        out_col_nxt  = oc_col + DIM_W'(1);
        pick_col_nxt = col_pick[DIM_W-1:0];
        rem_col_nxt  = col_wrap ? col_sub[DIM_W-1:0] : col_sum[DIM_W-1:0];
      end
      if (row_end) begin
        src_col_nxt = '0;
        if (row_sel) begin
          out_row_nxt  = oc_row + DIM_W'(1);
          out_col_nxt  = '0;
          pick_col_nxt = '0;
          rem_col_nxt  = '0;
          pick_row_nxt = row_pick[DIM_W-1:0];
          rem_row_nxt  = row_wrap ? row_sub[DIM_W-1:0] : row_sum[DIM_W-1:0];
        end
        src_row_nxt = (({1'b0, src_row_r} + (DIM_W+1)'(1)) >= {1'b0, sh}) ?
                      '0 : src_row_r + DIM_W'(1);
      end else begin
        src_col_nxt = src_col_r + DIM_W'(1);
      end
    end
  end

  // Selected word into the queue
  always_comb begin
    q_push         = accept && emit;
    q_entry.pix    = in_word;
    q_entry.x      = oc_col[POS_W-1:0];
    q_entry.y      = oc_row[POS_W-1:0];
    q_entry.width  = fit_w_r;
    q_entry.height = fit_h_r;
    q_entry.last   = (({1'b0, oc_col} + (DIM_W+1)'(1)) == {1'b0, fit_w_r}) &&
                     (({1'b0, oc_row} + (DIM_W+1)'(1)) == {1'b0, fit_h_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r  <= '0;
      src_row_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      pick_col_r <= '0;
      pick_row_r <= '0;
      rem_col_r  <= '0;
      rem_row_r  <= '0;
    end else begin
      src_col_r  <= src_col_nxt;
      src_row_r  <= src_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      pick_col_r <= pick_col_nxt;
      pick_row_r <= pick_row_nxt;
      rem_col_r  <= rem_col_nxt;
      rem_row_r  <= rem_row_nxt;
    end
  end

  // The thumbnail never grows beyond the source
  a_shrink_only: assert property (@(posedge clk) disable iff (!rst_n)
    dims_ok_r |-> (fit_w_r <= sw && fit_h_r <= sh && fit_w_r != '0 && fit_h_r != '0))
    else $error("fitted size out of range");

  // Stepping remainders stay below their divisors within a frame
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dims_ok_r && !frame_start) |-> (rem_col_r < fit_w_r && rem_row_r < fit_h_r))
    else $error("stepping remainder overflow");

  // No word is taken while the size is being worked out
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != SEQ_IDLE) |-> !accept)
    else $error("word accepted during size computation");

endmodule

/* rtl/core/afnd_queue.sv */
// Short register queue decoupling pixel selection from the output stage.
// Depends on afnd_pkg for the entry type and depth.
module afnd_queue import afnd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  sel_entry_t wr_entry,
  output logic       q_full,
  input  logic       rd_en,
  output sel_entry_t rd_entry,
  output logic       q_empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sel_entry_t       entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  // Pointer and fill bookkeeping
  always_comb begin
    q_full     = count_r == CNT_W'(QUEUE_DEPTH);
    q_empty    = count_r == '0;
    do_wr      = wr_en && !q_full;
    do_rd      = rd_en && !q_empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) count_nxt = count_r + CNT_W'(1);
    else if (do_rd && !do_wr) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_wr) entry_r[wr_ptr_r] <= wr_entry;
  end

  assign rd_entry = entry_r[rd_ptr_r];

  // Fill level stays within the storage
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill level overflow");

endmodule

/* rtl/core/afnd_back.sv */
// Back end: pulls selected pixels from the queue, reorders to BGRA and holds
// the result word for the consumer. Depends on afnd_pkg.
module afnd_back import afnd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  sel_entry_t q_entry,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output out_word_t  out_word
);

  logic      valid_r, valid_nxt;
  out_word_t word_r, word_nxt;
  logic      load;

  // Refill the output register whenever it is free or being taken
  always_comb begin
    load      = !q_empty && (!valid_r || pop);
    valid_nxt = load ? 1'b1 : (pop ? 1'b0 : valid_r);
    word_nxt  = word_r;
    if (load) begin
      word_nxt.out_blue   = q_entry.pix.blue;
      word_nxt.out_green  = q_entry.pix.green;
      word_nxt.out_red    = q_entry.pix.red;
      word_nxt.out_alpha  = q_entry.pix.alpha;
      word_nxt.dst_x      = q_entry.x;
      word_nxt.dst_y      = q_entry.y;
      word_nxt.dst_width  = q_entry.width;
      word_nxt.dst_height = q_entry.height;
      word_nxt.frame_last = q_entry.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    word_r <= word_nxt;
  end

  assign q_pop    = load;
  assign empty    = !valid_r;
  assign out_word = word_r;

endmodule

/* rtl/core/aspect_fit_nearest_downscaler_top.sv */
// Aspect-fit nearest-neighbour downscaler, top level. Depends on afnd_pkg.
// A selected pixel is written into the queue, then loaded into the output register that drives
// out_word when that register is free. Throughput: one source pixel per cycle while the queue
// has room and the size is known. After reset and after each register write, full stays high while
// the shared bit-serial divider works out the step sizes, first fitting the size if the source must shrink.
// Reset (synchronous, rst_n low) restores max_side 256 and a 1 x 1 source.
module aspect_fit_nearest_downscaler_top import afnd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  in_word_t              in_word,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output out_word_t             out_word
);

  div_req_t   div_req;
  div_rsp_t   div_rsp;
  sel_entry_t wr_entry, rd_entry;
  logic       q_push, q_pop, q_full, q_empty;

  // Shared divider for the size work after reset and register writes
  afnd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // Selection front end
  afnd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .push     (push),
    .in_word  (in_word),
    .full     (full),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (wr_entry),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  // Decoupling queue
  afnd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_entry (wr_entry),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_entry (rd_entry),
    .q_empty  (q_empty)
  );

  // Output stage
  afnd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_entry  (rd_entry),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule
